@@ design/bloom_filter_probe_engine_macros.svh @@
// Assertion helpers used by the bloom filter probe engine.
`ifndef BLOOM_FILTER_PROBE_ENGINE_MACROS_SVH
`define BLOOM_FILTER_PROBE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BFPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bfpe_pkg.sv @@
package bfpe_pkg;

   localparam int KEY_W      = 32;
   localparam int PPK_W      = 6;
   localparam int MAXK_W     = 17;
   localparam int PROD_W     = 25;
   localparam int ROT_RIGHT  = 17;
   localparam int MIN_BITS   = 64;
   localparam int BIT_W      = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(KEY_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_PROBES_PER_KEY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_KEYS       = 8'd1;

   localparam logic [PPK_W-1:0]  PPK_RESET  = 6'd10;
   localparam logic [MAXK_W-1:0] MAXK_RESET = 17'd1024;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TEST = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SIZE,
      ST_MOD,
      ST_WFIX,
      ST_PROBE_RD,
      ST_PROBE_WR,
      ST_DONE
   } state_type;

   // Which operand the shared remainder unit is reducing.
   typedef enum logic [1:0] {
      OPND_HASH,
      OPND_DELTA,
      OPND_WRAP
   } opnd_type;

endpackage

@@ design/bloom_filter_probe_engine.sv @@
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_mode, req_key_hash
// rsp      out        rsp_valid / rsp_stall   rsp_maybe_present
// csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// After reset the filter array is swept to zero, one byte per cycle; no item is
// taken during that pass, register writes are. An item is sized, then the
// bit-serial remainder unit reduces the hash, the delta and 2^32 - 1 by the
// filter size, and then each of its n probes, n being the probe count, is a
// byte read and a byte write on the array. The next item is taken once the
// result sits in the output register; a stalled result holds the engine in its
// last step.
`include "bloom_filter_probe_engine_macros.svh"

module bloom_filter_probe_engine #(
   parameter int ARRAY_BITS = 65536,
   parameter int MAX_PROBES = 32
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [bfpe_pkg::KEY_W-1:0]         req_key_hash,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_maybe_present,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfpe_pkg::CSR_DATA_W-1:0]    csr_data
);

   import bfpe_pkg::*;

   // The array holds whole bytes; the usable size saturates at that many bits.
   localparam int ARRAY_BYTES = ARRAY_BITS / 8;
   localparam int ABW         = $clog2(ARRAY_BYTES);
   localparam int SW          = $clog2(ARRAY_BITS + 1);
   localparam int PCW         = $clog2(MAX_PROBES + 1);
   localparam int NCW         = PPK_W + 1;

   localparam logic [PROD_W-1:0] SIZE_CAP = PROD_W'(ARRAY_BYTES * 8);
   localparam logic [PROD_W-1:0] SIZE_MIN = PROD_W'(MIN_BITS);
   localparam logic [ABW-1:0]    CLR_LAST = ABW'(ARRAY_BYTES - 1);

   // Control state.
   state_type           state_ff, state_in;
   logic [PPK_W-1:0]    ppk_ff, ppk_in;
   logic [MAXK_W-1:0]   maxk_ff, maxk_in;
   logic [ABW-1:0]      clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item working registers.
   logic                mode_ff, mode_in;
   logic [KEY_W-1:0]    h_ff, h_in;
   logic [KEY_W-1:0]    delta_ff, delta_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [PCW-1:0]      n_ff, n_in;
   logic [KEY_W-1:0]    dvd_ff, dvd_in;
   logic [SW-1:0]       rem_ff, rem_in;
   logic [BIT_W-1:0]    bitcnt_ff, bitcnt_in;
   opnd_type            opnd_ff, opnd_in;
   logic [SW-1:0]       pos_ff, pos_in;
   logic [SW-1:0]       dm_ff, dm_in;
   logic [SW-1:0]       wm_ff, wm_in;
   logic [SW-1:0]       tmp_ff, tmp_in;
   logic [PCW-1:0]      probe_ff, probe_in;
   logic                present_ff, present_in;
   logic                rsp_mp_ff, rsp_mp_in;

   // Filter array port.
   logic [7:0]          mem [ARRAY_BYTES];
   logic [7:0]          mem_rdata_ff;
   logic [ABW-1:0]      mem_raddr;
   logic [ABW-1:0]      mem_waddr;
   logic [7:0]          mem_wdata;
   logic                mem_we;

   // Datapath terms.
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   floored;
   logic [PROD_W-1:0]   rounded_p7;
   logic [PROD_W-1:0]   rounded;
   logic [PROD_W-1:0]   capped;
   logic [SW:0]         size_x;
   logic [SW:0]         trial;
   logic [SW-1:0]       rem_next;
   logic [SW:0]         wrap_plus1;
   logic [SW:0]         step_sum;
   logic [SW:0]         step_diff;
   logic [KEY_W:0]      h_sum;
   logic [7:0]          bit_mask;
   logic [PCW:0]        probe_next;
   logic                mod_last;
   logic                last_probe;
   logic                out_free;
   logic                csr_we;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_mp_ff;
   // Register writes are taken in every cycle, the clearing pass included.
   assign csr_ready         = 1'b1;
   assign csr_we            = csr_valid && csr_ready;

   // Active size: product, floor at the minimum, round up to a byte, cap.
   assign prod       = PROD_W'(maxk_ff) * PROD_W'(ppk_ff);
   assign floored    = (prod < SIZE_MIN) ? SIZE_MIN : prod;
   assign rounded_p7 = floored + PROD_W'(7);
   assign rounded    = {rounded_p7[PROD_W-1:3], 3'b000};
   assign capped     = (rounded > SIZE_CAP) ? SIZE_CAP : rounded;

   assign size_x = {1'b0, size_ff};

   // One restoring step of the shared remainder unit.
   assign trial    = {rem_ff, dvd_ff[KEY_W-1]};
   assign rem_next = (trial >= size_x) ? SW'(trial - size_x) : SW'(trial);
   assign mod_last = (bitcnt_ff == BIT_LAST);

   // 2^32 mod S is ((2^32 - 1) mod S) + 1, folded back once.
   assign wrap_plus1 = {1'b0, wm_ff} + (SW + 1)'(1);

   // Incremental position: add delta mod S, and on a 32-bit wrap of the hash
   // take 2^32 mod S back out.
   assign step_sum  = {1'b0, pos_ff} + {1'b0, dm_ff};
   assign step_diff = {1'b0, tmp_ff} - {1'b0, wm_ff};
   assign h_sum     = {1'b0, h_ff} + {1'b0, delta_ff};

   assign bit_mask   = 8'b1 << pos_ff[2:0];
   assign probe_next = {1'b0, probe_ff} + (PCW + 1)'(1);
   assign last_probe = (probe_next == {1'b0, n_ff});
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign mem_raddr = ABW'(pos_ff >> 3);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (mod_last && (opnd_ff == OPND_WRAP)) begin
               state_in = ST_WFIX;
            end
         end
         ST_WFIX: begin
            state_in = (n_ff == '0) ? ST_DONE : ST_PROBE_RD;
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_WR;
         end
         ST_PROBE_WR: begin
            state_in = last_probe ? ST_DONE : ST_PROBE_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      ppk_in       = ppk_ff;
      maxk_in      = maxk_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mp_in    = rsp_mp_ff;
      mode_in      = mode_ff;
      h_in         = h_ff;
      delta_in     = delta_ff;
      size_in      = size_ff;
      n_in         = n_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      bitcnt_in    = bitcnt_ff;
      opnd_in      = opnd_ff;
      pos_in       = pos_ff;
      dm_in        = dm_ff;
      wm_in        = wm_ff;
      tmp_in       = tmp_ff;
      probe_in     = probe_ff;
      present_in   = present_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = 8'h00;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PROBES_PER_KEY: ppk_in  = csr_data[PPK_W-1:0];
            CSR_MAX_KEYS:       maxk_in = csr_data[MAXK_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + ABW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               h_in      = req_key_hash;
               delta_in  = {req_key_hash[ROT_RIGHT-1:0], req_key_hash[KEY_W-1:ROT_RIGHT]};
               dvd_in    = req_key_hash;
               rem_in    = '0;
               bitcnt_in = '0;
               opnd_in   = OPND_HASH;
            end
         end
         ST_SIZE: begin
            size_in = SW'(capped);
            n_in    = ({1'b0, ppk_ff} > NCW'(MAX_PROBES)) ? PCW'(MAX_PROBES)
                                                          : PCW'(ppk_ff);
         end
         ST_MOD: begin
            rem_in    = rem_next;
            dvd_in    = dvd_ff << 1;
            bitcnt_in = bitcnt_ff + BIT_W'(1);
            if (mod_last) begin
               rem_in = '0;
               case (opnd_ff)
                  OPND_HASH: begin
                     pos_in  = rem_next;
                     dvd_in  = delta_ff;
                     opnd_in = OPND_DELTA;
                  end
                  OPND_DELTA: begin
                     dm_in   = rem_next;
                     dvd_in  = '1;
                     opnd_in = OPND_WRAP;
                  end
                  default: begin
                     wm_in = rem_next;
                  end
               endcase
            end
         end
         ST_WFIX: begin
            wm_in      = (wrap_plus1 == size_x) ? '0 : SW'(wrap_plus1);
            probe_in   = '0;
            present_in = 1'b1;
         end
         ST_PROBE_RD: begin
            tmp_in = (step_sum >= size_x) ? SW'(step_sum - size_x) : SW'(step_sum);
         end
         ST_PROBE_WR: begin
            mem_waddr = mem_raddr;
            mem_wdata = mem_rdata_ff | bit_mask;
            if (mode_ff == MODE_TEST) begin
               if ((mem_rdata_ff & bit_mask) == 8'h00) begin
                  present_in = 1'b0;
               end
            end else begin
               mem_we = 1'b1;
            end
            h_in = h_sum[KEY_W-1:0];
            if (h_sum[KEY_W]) begin
               pos_in = step_diff[SW] ? SW'(step_diff + size_x) : SW'(step_diff);
            end else begin
               pos_in = tmp_ff;
            end
            probe_in = PCW'(probe_next);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mp_in    = (mode_ff == MODE_TEST) ? present_ff : 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ppk_ff       <= PPK_RESET;
         maxk_ff      <= MAXK_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ppk_ff       <= ppk_in;
         maxk_ff      <= maxk_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item working registers.
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      h_ff       <= h_in;
      delta_ff   <= delta_in;
      size_ff    <= size_in;
      n_ff       <= n_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      bitcnt_ff  <= bitcnt_in;
      opnd_ff    <= opnd_in;
      pos_ff     <= pos_in;
      dm_ff      <= dm_in;
      wm_ff      <= wm_in;
      tmp_ff     <= tmp_in;
      probe_ff   <= probe_in;
      present_ff <= present_in;
      rsp_mp_ff  <= rsp_mp_in;
   end

   // Filter array: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   `BFPE_ASSERT_IMP(a_rem_in_range, clock, reset, state_ff == ST_MOD, rem_ff < size_ff, "remainder not below filter size")
   `BFPE_ASSERT_IMP(a_pos_in_range, clock, reset, (state_ff == ST_PROBE_RD) || (state_ff == ST_PROBE_WR), pos_ff < size_ff, "probe position outside active filter")
   `BFPE_ASSERT_IMP(a_residues_in_range, clock, reset, state_ff == ST_PROBE_RD, (dm_ff < size_ff) && (wm_ff < size_ff), "step residues not reduced")
   `BFPE_ASSERT_IMP(a_add_answers_zero, clock, reset, $rose(rsp_valid_ff) && (mode_ff == MODE_ADD), !rsp_mp_ff, "add item answered present")
   `BFPE_ASSERT_NXT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "finished item not delivered")

endmodule
